### design/assert_macros.svh
// Assertion macros used by the palette fade engine sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define PFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every rising clock edge outside of reset.
`define PFE_ASSERT_IMPLY(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`endif

### design/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

    typedef enum logic [2:0] {
        FUNC_WR_REF  = 3'd0,
        FUNC_WR_CUR  = 3'd1,
        FUNC_RD_CUR  = 3'd2,
        FUNC_FADE_IN = 3'd3,
        FUNC_FADE_OUT = 3'd4,
        FUNC_BLANK   = 3'd5
    } func_t;

    localparam logic CFG_FADE_START  = 1'b0;
    localparam logic CFG_FADE_LENGTH = 1'b1;

    localparam logic [5:0] FADE_START_RESET  = 6'd0;
    localparam logic [6:0] FADE_LENGTH_RESET = 7'd64;

    localparam logic [15:0] STEP_HI  = 16'h0200;
    localparam logic [15:0] STEP_MID = 16'h0020;
    localparam logic [15:0] STEP_LO  = 16'h0002;
    localparam logic [15:0] MASK_LO  = 16'h000E;
    localparam logic [15:0] MASK_MID = 16'h00E0;
    localparam logic [15:0] MASK_HI  = 16'h0E00;

    typedef struct packed {
        logic        rd_en;
        logic        wr_cur_dry;
        logic        wr_cur_wet;
        logic        wr_ref_dry;
        logic        wr_ref_wet;
        logic [15:0] data_dry;
        logic [15:0] data_wet;
    } mem_cmd_t;

    typedef struct packed {
        logic [15:0] cur_dry;
        logic [15:0] cur_wet;
        logic [15:0] ref_dry;
        logic [15:0] ref_wet;
    } mem_rsp_t;

    function automatic logic [15:0] step_in(input logic [15:0] v, input logic [15:0] target);
        logic [16:0] sum_hi;
        logic [16:0] sum_mid;
        logic [16:0] sum_lo;
        logic [16:0] lim;
        logic [15:0] res;
        sum_hi  = {1'b0, v} + {1'b0, STEP_HI};
        sum_mid = {1'b0, v} + {1'b0, STEP_MID};
        sum_lo  = {1'b0, v} + {1'b0, STEP_LO};
        lim     = {1'b0, target};
        if (sum_hi <= lim)
        begin
            res = sum_hi[15:0];
        end
        else if (sum_mid <= lim)
        begin
            res = sum_mid[15:0];
        end
        else if (sum_lo <= lim)
        begin
            res = sum_lo[15:0];
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [15:0] step_out(input logic [15:0] v);
        logic [15:0] res;
        if ((v & MASK_LO) != 16'h0000)
        begin
            res = v - STEP_LO;
        end
        else if ((v & MASK_MID) != 16'h0000)
        begin
            res = v - STEP_MID;
        end
        else if ((v & MASK_HI) != 16'h0000)
        begin
            res = v - STEP_HI;
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/pfe_store.sv
`default_nettype none

module pfe_store
    import pfe_pkg::*;
#(
    parameter int ENTRIES = 64,
    localparam int AW = $clog2(ENTRIES)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mem_cmd_t      cmd,
    input  wire logic [AW-1:0] addr,
    output mem_rsp_t           rsp
);

    logic [31:0] cur_mem [ENTRIES];
    logic [31:0] ref_mem [ENTRIES];

    logic [ENTRIES-1:0] cur_dry_vld_reg;
    logic [ENTRIES-1:0] cur_wet_vld_reg;
    logic [ENTRIES-1:0] ref_dry_vld_reg;
    logic [ENTRIES-1:0] ref_wet_vld_reg;

    logic [31:0] cur_rd_reg;
    logic [31:0] ref_rd_reg;
    logic [3:0]  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_cur_dry)
        begin
            cur_mem[addr][15:0] <= cmd.data_dry;
        end
        if (cmd.wr_cur_wet)
        begin
            cur_mem[addr][31:16] <= cmd.data_wet;
        end
        if (cmd.wr_ref_dry)
        begin
            ref_mem[addr][15:0] <= cmd.data_dry;
        end
        if (cmd.wr_ref_wet)
        begin
            ref_mem[addr][31:16] <= cmd.data_wet;
        end
        if (cmd.rd_en)
        begin
            cur_rd_reg <= cur_mem[addr];
            ref_rd_reg <= ref_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_dry_vld_reg <= '0;
            cur_wet_vld_reg <= '0;
            ref_dry_vld_reg <= '0;
            ref_wet_vld_reg <= '0;
            rd_vld_reg      <= '0;
        end
        else
        begin
            if (cmd.wr_cur_dry)
            begin
                cur_dry_vld_reg[addr] <= 1'b1;
            end
            if (cmd.wr_cur_wet)
            begin
                cur_wet_vld_reg[addr] <= 1'b1;
            end
            if (cmd.wr_ref_dry)
            begin
                ref_dry_vld_reg[addr] <= 1'b1;
            end
            if (cmd.wr_ref_wet)
            begin
                ref_wet_vld_reg[addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_vld_reg <= {cur_dry_vld_reg[addr], cur_wet_vld_reg[addr],
                               ref_dry_vld_reg[addr], ref_wet_vld_reg[addr]};
            end
        end
    end

    assign rsp.cur_dry = rd_vld_reg[3] ? cur_rd_reg[15:0]  : 16'h0000;
    assign rsp.cur_wet = rd_vld_reg[2] ? cur_rd_reg[31:16] : 16'h0000;
    assign rsp.ref_dry = rd_vld_reg[1] ? ref_rd_reg[15:0]  : 16'h0000;
    assign rsp.ref_wet = rd_vld_reg[0] ? ref_rd_reg[31:16] : 16'h0000;

endmodule

`default_nettype wire

### design/pfe_sequencer.sv
`default_nettype none

`include "assert_macros.svh"

module pfe_sequencer
    import pfe_pkg::*;
#(
    parameter int ENTRIES = 64,
    localparam int AW = $clog2(ENTRIES),
    localparam int SW = (AW + 1 > 8) ? AW + 1 : 8
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [2:0]    func,
    input  wire logic          bank,
    input  wire logic [5:0]    entry,
    input  wire logic [15:0]   colour,
    output logic               done,
    output logic [15:0]        read_colour,
    input  wire logic          cfg_wr_en,
    input  wire logic          cfg_index,
    input  wire logic [6:0]    cfg_data,
    output mem_cmd_t           cmd,
    output logic [AW-1:0]      addr,
    input  wire mem_rsp_t      rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_WAIT,
        S_FADE_RD,
        S_FADE_WR,
        S_BLANK
    } state_t;

    state_t      state_reg;
    logic [SW-1:0] idx_reg;
    logic        fade_in_reg;
    logic        bank_reg;
    logic        ok_reg;
    logic        done_reg;
    logic [15:0] read_colour_reg;
    logic [5:0]  fade_start_reg;
    logic [6:0]  fade_length_reg;

    logic [SW-1:0] range_sum;
    logic [SW-1:0] range_end;
    logic [SW-1:0] start_ext;
    logic [SW-1:0] idx_next;
    logic          range_empty;
    logic          entry_ok;
    logic          accept;
    logic          last_entry;

    assign start_ext   = SW'(fade_start_reg);
    assign range_sum   = start_ext + SW'(fade_length_reg);
    assign range_end   = (range_sum > SW'(ENTRIES)) ? SW'(ENTRIES) : range_sum;
    assign range_empty = !(start_ext < range_end);
    assign idx_next    = idx_reg + SW'(1);
    assign last_entry  = (idx_next == range_end);
    assign entry_ok    = (SW'(entry) < SW'(ENTRIES));
    assign accept      = start && (state_reg == S_IDLE);
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign read_colour = read_colour_reg;

    always_comb
    begin
        cmd  = '0;
        addr = '0;
        case (state_reg)
            S_IDLE:
            begin
                addr = AW'(entry);
                cmd.data_dry = colour;
                cmd.data_wet = colour;
                if (start)
                begin
                    case (func_t'(func))
                        FUNC_WR_REF:
                        begin
                            cmd.wr_ref_dry = entry_ok && !bank;
                            cmd.wr_ref_wet = entry_ok && bank;
                        end
                        FUNC_WR_CUR:
                        begin
                            cmd.wr_cur_dry = entry_ok && !bank;
                            cmd.wr_cur_wet = entry_ok && bank;
                        end
                        FUNC_RD_CUR:
                        begin
                            cmd.rd_en = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FADE_RD:
            begin
                addr      = idx_reg[AW-1:0];
                cmd.rd_en = 1'b1;
            end
            S_FADE_WR:
            begin
                addr           = idx_reg[AW-1:0];
                cmd.wr_cur_dry = 1'b1;
                cmd.wr_cur_wet = 1'b1;
                cmd.data_dry   = fade_in_reg ? step_in(rsp.cur_dry, rsp.ref_dry)
                                             : step_out(rsp.cur_dry);
                cmd.data_wet   = fade_in_reg ? step_in(rsp.cur_wet, rsp.ref_wet)
                                             : step_out(rsp.cur_wet);
            end
            S_BLANK:
            begin
                addr           = idx_reg[AW-1:0];
                cmd.wr_cur_dry = 1'b1;
                cmd.data_dry   = 16'h0000;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            fade_in_reg     <= 1'b0;
            bank_reg        <= 1'b0;
            ok_reg          <= 1'b0;
            done_reg        <= 1'b0;
            read_colour_reg <= 16'h0000;
            fade_start_reg  <= FADE_START_RESET;
            fade_length_reg <= FADE_LENGTH_RESET;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_FADE_START:  fade_start_reg  <= cfg_data[5:0];
                    CFG_FADE_LENGTH: fade_length_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        read_colour_reg <= 16'h0000;
                        bank_reg        <= bank;
                        ok_reg          <= entry_ok;
                        idx_reg         <= start_ext;
                        case (func_t'(func))
                            FUNC_RD_CUR:
                            begin
                                state_reg <= S_READ_WAIT;
                            end
                            FUNC_FADE_IN, FUNC_FADE_OUT:
                            begin
                                fade_in_reg <= (func_t'(func) == FUNC_FADE_IN);
                                if (range_empty)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_FADE_RD;
                                end
                            end
                            FUNC_BLANK:
                            begin
                                if (range_empty)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_BLANK;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ_WAIT:
                begin
                    done_reg <= 1'b1;
                    if (ok_reg)
                    begin
                        read_colour_reg <= bank_reg ? rsp.cur_wet : rsp.cur_dry;
                    end
                    state_reg <= S_IDLE;
                end
                S_FADE_RD:
                begin
                    state_reg <= S_FADE_WR;
                end
                S_FADE_WR:
                begin
                    idx_reg <= idx_next;
                    if (last_entry)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_FADE_RD;
                    end
                end
                S_BLANK:
                begin
                    idx_reg <= idx_next;
                    if (last_entry)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PFE_ASSERT_IMPLY(a_idx_in_range, (state_reg == S_FADE_WR) || (state_reg == S_BLANK), idx_reg < range_end, "Fade index left the range.")
    `PFE_ASSERT(a_no_rd_wr_mix, !(cmd.rd_en && (cmd.wr_cur_dry || cmd.wr_cur_wet || cmd.wr_ref_dry || cmd.wr_ref_wet)), "Read and write issued together.")
    `PFE_ASSERT_IMPLY(a_read_latency, accept && (func_t'(func) == FUNC_RD_CUR), ##2 done, "Read item did not finish in two cycles.")
    `PFE_ASSERT_IMPLY(a_done_when_idle, done, state_reg == S_IDLE, "Result strobe while still busy.")

endmodule

`default_nettype wire

### design/palette_fade_engine.sv
`default_nettype none

// Palette fade engine. An item is taken at a rising edge with start high and busy low, and
// every item gives one result: done is high for exactly one cycle and read_colour holds the
// addressed colour for a read and zero otherwise. The receiver cannot stall, so the result
// must be captured in that cycle. A reference or current write gives done in the cycle after
// it is taken; a read first passes through the read-wait state, which takes the registered
// memory word. A fade tick visits each entry of the clipped fade range with a read and then
// a write of the single-port palette memories; blackening writes one entry a cycle. An
// empty range gives done in the cycle after it is taken. busy is low again in the cycle in
// which done is high, so the next item may be taken then.
// Configuration writes are taken at any edge with cfg_wr_en high and must only be issued
// while busy is low. After reset all palette entries read as zero with no clearing pass.

module palette_fade_engine
    import pfe_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  func,
    input  wire logic        bank,
    input  wire logic [5:0]  entry,
    input  wire logic [15:0] colour,
    output logic             done,
    output logic [15:0]      read_colour,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    mem_cmd_t      cmd;
    mem_rsp_t      rsp;
    logic [AW-1:0] addr;

    pfe_sequencer #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .bank        (bank),
        .entry       (entry),
        .colour      (colour),
        .done        (done),
        .read_colour (read_colour),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .addr        (addr),
        .rsp         (rsp)
    );

    pfe_store #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .addr  (addr),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
